// ===== src/fwat_pkg.sv =====
package fwat_pkg;

  // store geometry
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // field widths
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned FRAC_W = 17;
  localparam int unsigned LVL_W  = 34;

  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(32768);

  // command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  // request to the multiply/divide unit: off = num * mdx / den
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] num;
    logic [VAL_W-1:0] mdx;
    logic [VAL_W-1:0] den;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
  } md_rsp_t;

endpackage

// ===== src/full_width_at_threshold.sv =====
// Load: one cycle per point; busy_o stays low, so loads may follow back to back.
// Measure of n points: a peak scan, then a walk down and a walk up point by point,
// and one interpolation per crossing in the shared multiply/divide unit; n <= 2
// answers without a scan. One measure at a time (busy_o high meanwhile).
// The result shows for one cycle on done_o; the receiver cannot stall it.
// Reset clears point count, overflow and busy; level_fraction resets to one half.
module full_width_at_threshold (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         level_fraction_we_i,
  input  logic [fwat_pkg::FRAC_W-1:0]  level_fraction_i,
  input  logic                         cmd_i,
  input  logic signed [31:0]           point_x_i,
  input  logic signed [31:0]           point_y_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic signed [31:0]           edge_start_o,
  output logic signed [31:0]           edge_end_o,
  output logic [31:0]                  width_o,
  output logic signed [31:0]           center_o,
  output logic                         overflowed_o
);

  localparam int unsigned AW = fwat_pkg::ADDR_W;
  localparam int unsigned CW = fwat_pkg::CNT_W;
  localparam int unsigned LW = fwat_pkg::LVL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PK_RD, S_PK_USE, S_LVL, S_DN_STEP, S_DN_RD, S_DN_USE,
    S_UP_STEP, S_UP_RD, S_UP_USE, S_CX_RA, S_CX_A, S_CX_RB, S_CX_B, S_CX_WAIT
  } state_e;

  state_e                       st_q;
  logic [CW-1:0]                count_q;
  logic                         ovf_q;
  logic [fwat_pkg::FRAC_W-1:0]  frac_q;
  logic [AW-1:0]                idx_q;
  logic [AW-1:0]                mi_q;
  logic signed [31:0]           peak_q;
  logic signed [LW-1:0]         lvl_q;
  logic signed [31:0]           y2_q;
  logic signed [31:0]           ya_q;
  logic signed [31:0]           yb_q;
  logic signed [31:0]           xa_q;
  logic signed [31:0]           s_q;
  logic                         phase_q;
  logic                         dxneg_q;
  fwat_pkg::md_req_t            req_q;
  fwat_pkg::md_rsp_t            rsp;

  logic [31:0] x_rd, y_rd;
  logic        load_fire, meas_fire, ram_we;

  assign busy_o    = (st_q != S_IDLE);
  assign load_fire = start_i && !busy_o && (cmd_i == fwat_pkg::CMD_LOAD);
  assign meas_fire = start_i && !busy_o && (cmd_i == fwat_pkg::CMD_MEASURE);
  assign ram_we    = load_fire && (count_q < CW'(fwat_pkg::DEPTH));

  fwat_ram #(.WIDTH(32), .DEPTH(fwat_pkg::DEPTH)) u_xram (
    .clk_i, .we_i(ram_we), .waddr_i(count_q[AW-1:0]), .wdata_i(point_x_i),
    .raddr_i(idx_q), .rdata_o(x_rd)
  );

  fwat_ram #(.WIDTH(32), .DEPTH(fwat_pkg::DEPTH)) u_yram (
    .clk_i, .we_i(ram_we), .waddr_i(count_q[AW-1:0]), .wdata_i(point_y_i),
    .raddr_i(idx_q), .rdata_o(y_rd)
  );

  fwat_muldiv u_md (.clk_i, .rst_ni, .req_i(req_q), .rsp_o(rsp));

  // level = floor(peak * fraction / 65536)
  logic signed [49:0] prod;
  assign prod = peak_q * $signed({1'b0, frac_q});

  // read data seen as signed values
  logic signed [31:0] yr_s, xr_s;
  logic signed [LW-1:0] yr_ext, y2_ext;
  assign yr_s   = $signed(y_rd);
  assign xr_s   = $signed(x_rd);
  assign yr_ext = LW'(yr_s);
  assign y2_ext = LW'(y2_q);

  // crossing setup from xa, xb (read data), ya, yb
  logic signed [32:0] dx, dy;
  logic signed [LW:0] dl;
  logic [32:0]        mdx_w, den_w;
  logic [LW:0]        adl;
  logic [31:0]        num_w;
  assign dx    = 33'(xr_s) - 33'(xa_q);
  assign dy    = 33'(yb_q) - 33'(ya_q);
  assign dl    = (LW+1)'(lvl_q) - (LW+1)'(ya_q);
  assign mdx_w = dx[32] ? 33'(-dx) : 33'(dx);
  assign den_w = dy[32] ? 33'(-dy) : 33'(dy);
  assign adl   = dl[LW] ? (LW+1)'(-dl) : (LW+1)'(dl);
  assign num_w = (adl > (LW+1)'(den_w)) ? den_w[31:0] : adl[31:0];

  // crossing from unit quotient
  logic [31:0] cross_w;
  assign cross_w = dxneg_q ? xa_q - rsp.quot : xa_q + rsp.quot;

  // finished crossing value, either flat segment or interpolated
  logic        cx_done;
  logic [31:0] cx_val;
  assign cx_done = (st_q == S_CX_B && dy == '0) || (st_q == S_CX_WAIT && rsp.done);
  assign cx_val  = (st_q == S_CX_B) ? xa_q : cross_w;

  // result fields for a found pair
  logic signed [32:0] sum_w;
  assign sum_w = 33'(s_q) + 33'(signed'(cx_val));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      frac_q       <= fwat_pkg::FRAC_RESET;
      done_o       <= 1'b0;
      req_q        <= '0;
      phase_q      <= 1'b0;
      found_o      <= 1'b0;
      edge_start_o <= '0;
      edge_end_o   <= '0;
      width_o      <= '0;
      center_o     <= '0;
      overflowed_o <= 1'b0;
      idx_q        <= '0;
      mi_q         <= '0;
      peak_q       <= '0;
      lvl_q        <= '0;
      y2_q         <= '0;
      ya_q         <= '0;
      yb_q         <= '0;
      xa_q         <= '0;
      s_q          <= '0;
      dxneg_q      <= 1'b0;
    end else begin
      done_o      <= 1'b0;
      req_q.start <= 1'b0;
      if (level_fraction_we_i) begin
        frac_q <= level_fraction_i;
      end
      unique case (st_q)
        S_IDLE: begin
          if (load_fire) begin
            if (ram_we) begin
              count_q <= count_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end else if (meas_fire) begin
            if (count_q <= CW'(2)) begin
              done_o       <= 1'b1;
              found_o      <= 1'b0;
              edge_start_o <= '0;
              edge_end_o   <= '0;
              width_o      <= '0;
              center_o     <= '0;
              overflowed_o <= ovf_q;
              count_q      <= '0;
              ovf_q        <= 1'b0;
            end else begin
              idx_q <= '0;
              st_q  <= S_PK_RD;
            end
          end
        end
        // first maximum over points 0 to n-2
        S_PK_RD: st_q <= S_PK_USE;
        S_PK_USE: begin
          if (idx_q == '0 || yr_s > peak_q) begin
            peak_q <= yr_s;
            mi_q   <= idx_q;
          end
          if (CW'(idx_q) == count_q - CW'(2)) begin
            st_q <= S_LVL;
          end else begin
            idx_q <= idx_q + AW'(1);
            st_q  <= S_PK_RD;
          end
        end
        S_LVL: begin
          lvl_q   <= prod[49:16];
          idx_q   <= mi_q;
          y2_q    <= peak_q;
          phase_q <= 1'b0;
          st_q    <= S_DN_STEP;
        end
        // rising crossing, walking down
        S_DN_STEP: begin
          if (idx_q == '0) begin
            done_o       <= 1'b1;
            found_o      <= 1'b0;
            edge_start_o <= '0;
            edge_end_o   <= '0;
            width_o      <= '0;
            center_o     <= '0;
            overflowed_o <= ovf_q;
            count_q      <= '0;
            ovf_q        <= 1'b0;
            st_q         <= S_IDLE;
          end else begin
            idx_q <= idx_q - AW'(1);
            st_q  <= S_DN_RD;
          end
        end
        S_DN_RD: st_q <= S_DN_USE;
        S_DN_USE: begin
          if (yr_ext <= lvl_q && lvl_q <= y2_ext) begin
            ya_q <= yr_s;
            yb_q <= y2_q;
            st_q <= S_CX_RA;
          end else begin
            y2_q <= yr_s;
            st_q <= S_DN_STEP;
          end
        end
        // falling crossing, walking up; y2_q holds the lower-index value
        S_UP_STEP: begin
          if (CW'(idx_q) + CW'(1) >= count_q) begin
            done_o       <= 1'b1;
            found_o      <= 1'b0;
            edge_start_o <= '0;
            edge_end_o   <= '0;
            width_o      <= '0;
            center_o     <= '0;
            overflowed_o <= ovf_q;
            count_q      <= '0;
            ovf_q        <= 1'b0;
            st_q         <= S_IDLE;
          end else begin
            idx_q <= idx_q + AW'(1);
            st_q  <= S_UP_RD;
          end
        end
        S_UP_RD: st_q <= S_UP_USE;
        S_UP_USE: begin
          if (y2_ext >= lvl_q && lvl_q >= yr_ext) begin
            ya_q  <= y2_q;
            yb_q  <= yr_s;
            idx_q <= idx_q - AW'(1);
            st_q  <= S_CX_RA;
          end else begin
            y2_q <= yr_s;
            st_q <= S_UP_STEP;
          end
        end
        // crossing between idx and idx+1
        S_CX_RA: st_q <= S_CX_A;
        S_CX_A: begin
          xa_q  <= xr_s;
          idx_q <= idx_q + AW'(1);
          st_q  <= S_CX_RB;
        end
        S_CX_RB: st_q <= S_CX_B;
        S_CX_B: begin
          if (dy != '0) begin
            dxneg_q     <= dx[32];
            req_q.start <= 1'b1;
            req_q.num   <= num_w;
            req_q.mdx   <= mdx_w[31:0];
            req_q.den   <= den_w[31:0];
            st_q        <= S_CX_WAIT;
          end
        end
        S_CX_WAIT: ;
        default: st_q <= S_IDLE;
      endcase

      // crossing finished: start next walk or report
      if (cx_done) begin
        if (!phase_q) begin
          s_q     <= cx_val;
          phase_q <= 1'b1;
          idx_q   <= mi_q;
          y2_q    <= peak_q;
          st_q    <= S_UP_STEP;
        end else begin
          done_o       <= 1'b1;
          found_o      <= 1'b1;
          edge_start_o <= s_q;
          edge_end_o   <= cx_val;
          width_o      <= cx_val - s_q;
          center_o     <= sum_w[32:1];
          overflowed_o <= ovf_q;
          count_q      <= '0;
          ovf_q        <= 1'b0;
          st_q         <= S_IDLE;
        end
      end
    end
  end

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |=> !done_o) else $error("load produced a result");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (edge_start_o == '0 && width_o == '0 && center_o == '0))
    else $error("missing crossing with nonzero fields");

  a_width_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> width_o == 32'(edge_end_o - edge_start_o))
    else $error("width disagrees with edges");

  a_store_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (count_q == '0 && !ovf_q)) else $error("store not emptied");

endmodule

// ===== src/fwat_ram.sv =====
module fwat_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/fwat_muldiv.sv =====
module fwat_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fwat_pkg::md_req_t req_i,
  output fwat_pkg::md_rsp_t rsp_o
);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_LOAD, U_DIV} ustate_e;

  localparam int unsigned W = fwat_pkg::VAL_W;

  ustate_e               st_q;
  logic [4:0]            cnt_q;
  logic [2*W-1:0]        acc_q;
  logic [W-1:0]          sh_q;
  logic [W-1:0]          mdx_q;
  logic [W-1:0]          den_q;
  logic [W-1:0]          rem_q;
  logic [W-1:0]          qs_q;
  logic                  done_q;

  // one restoring step: shift in next dividend bit, trial subtract
  logic [W:0]            wide;
  logic [W+1:0]          diff;
  logic                  borrow;

  assign wide   = {rem_q, qs_q[W-1]};
  assign diff   = {1'b0, wide} - {2'b00, den_q};
  assign borrow = diff[W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= U_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
      acc_q  <= '0;
      sh_q   <= '0;
      mdx_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      qs_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        U_IDLE: begin
          if (req_i.start) begin
            acc_q <= '0;
            sh_q  <= req_i.num;
            mdx_q <= req_i.mdx;
            den_q <= req_i.den;
            cnt_q <= '0;
            st_q  <= U_MUL;
          end
        end
        // shift-add multiply, msb first
        U_MUL: begin
          acc_q <= {acc_q[2*W-2:0], 1'b0} + (sh_q[W-1] ? {{W{1'b0}}, mdx_q} : '0);
          sh_q  <= {sh_q[W-2:0], 1'b0};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            st_q <= U_LOAD;
          end
        end
        // upper half is below den since the quotient fits W bits
        U_LOAD: begin
          rem_q <= acc_q[2*W-1:W];
          qs_q  <= acc_q[W-1:0];
          cnt_q <= '0;
          st_q  <= U_DIV;
        end
        U_DIV: begin
          rem_q <= borrow ? wide[W-1:0] : diff[W-1:0];
          qs_q  <= {qs_q[W-2:0], ~borrow};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            done_q <= 1'b1;
            st_q   <= U_IDLE;
          end
        end
        default: st_q <= U_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = qs_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("unit done longer than one cycle");

  a_done_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(st_q) == U_DIV) else $error("unit done outside divide");

  a_busy_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == U_MUL) |=> (st_q == U_MUL || st_q == U_LOAD))
    else $error("multiply phase left early");

endmodule
